### hw/rtl/ccs_pkg.sv
// Shared types, character codes and helpers for the cytosine context scanner.
package ccs_pkg;

    localparam int POSITION_BITS_DEF = 32;
    localparam int OUTQ_DEPTH        = 4;   // power of two, at least 4

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_N = 8'h4E;
    localparam logic [7:0] CHAR_T = 8'h54;
    localparam logic [7:0] CHAR_LC_A = 8'h61;
    localparam logic [7:0] CHAR_LC_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic STRAND_PLUS  = 1'b0;
    localparam logic STRAND_MINUS = 1'b1;

    typedef struct packed {
        logic [31:0] position;
        logic        strand;
        logic [7:0]  ctx_second;
        logic [7:0]  ctx_third;
        logic        last_of_run;
    } t_rec;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
            r = c - CASE_OFFSET;
        end
        return r;
    endfunction

    function automatic logic [7:0] comp_base(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            CHAR_A:  r = CHAR_T;
            CHAR_T:  r = CHAR_A;
            CHAR_C:  r = CHAR_G;
            CHAR_G:  r = CHAR_C;
            default: r = CHAR_N;
        endcase
        return r;
    endfunction

    // Record for base b; valid only when b is C or G (see is_cg).
    function automatic t_rec judge(input logic [7:0] b, input logic [31:0] pos,
                                   input logic [7:0] nx1, input logic [7:0] nx2,
                                   input logic [7:0] pv1, input logic [7:0] pv2);
        t_rec r;
        r.position    = pos;
        r.last_of_run = 1'b0;
        if (b == CHAR_G) begin
            r.strand     = STRAND_MINUS;
            r.ctx_second = comp_base(pv1);
            r.ctx_third  = comp_base(pv2);
        end else begin
            r.strand     = STRAND_PLUS;
            r.ctx_second = nx1;
            r.ctx_third  = nx2;
        end
        return r;
    endfunction

    function automatic logic is_cg(input logic [7:0] b);
        return (b == CHAR_C) || (b == CHAR_G);
    endfunction

endpackage

### hw/rtl/ccs_cell.sv
// One window cell: holds one upper-cased base and passes it to the next cell.
module ccs_cell (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  logic       i_clear,
    input  logic [7:0] i_base,
    output logic [7:0] o_base
);
    import ccs_pkg::*;

    logic [7:0] r_base;
    logic [7:0] n_base;

    always_comb begin
        n_base = r_base;
        if (i_clear) begin
            n_base = CHAR_N;
        end else if (i_shift) begin
            n_base = i_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= CHAR_N;
        end else begin
            r_base <= n_base;
        end
    end

    assign o_base = r_base;

endmodule

### hw/rtl/ccs_outq.sv
// Record queue: takes up to three records per cycle, hands out one per beat.
module ccs_outq (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [2:0]   i_vld,
    input  ccs_pkg::t_rec i_rec0,
    input  ccs_pkg::t_rec i_rec1,
    input  ccs_pkg::t_rec i_rec2,
    output logic         o_room,
    output logic         o_valid,
    input  logic         i_ready,
    output ccs_pkg::t_rec o_rec
);
    import ccs_pkg::*;

    localparam int PW = $clog2(OUTQ_DEPTH);
    localparam int CW = $clog2(OUTQ_DEPTH + 1);

    t_rec            r_mem [OUTQ_DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic [PW-1:0]   n_wr;
    logic [PW-1:0]   n_rd;
    logic [CW-1:0]   n_cnt;
    logic [PW-1:0]   idx1;
    logic [PW-1:0]   idx2;
    logic [1:0]      push_n;
    logic            pop;

    assign idx1   = r_wr + PW'(i_vld[0]);
    assign idx2   = idx1 + PW'(i_vld[1]);
    assign push_n = 2'(i_vld[0]) + 2'(i_vld[1]) + 2'(i_vld[2]);
    assign pop    = o_valid && i_ready;

    always_comb begin
        n_wr  = r_wr + PW'(push_n);
        n_rd  = r_rd + PW'(pop);
        n_cnt = r_cnt + CW'(push_n) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < OUTQ_DEPTH; i++) begin
            if (i_vld[0] && PW'(i) == r_wr) begin
                r_mem[i] <= i_rec0;
            end
            if (i_vld[1] && PW'(i) == idx1) begin
                r_mem[i] <= i_rec1;
            end
            if (i_vld[2] && PW'(i) == idx2) begin
                r_mem[i] <= i_rec2;
            end
        end
    end

    // room for a full burst of three
    assign o_room  = r_cnt <= CW'(OUTQ_DEPTH - 3);
    assign o_valid = r_cnt != '0;
    assign o_rec   = r_mem[r_rd];

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(OUTQ_DEPTH))
        else $error("record queue over depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vld != 3'b000) |-> (r_cnt + CW'(push_n) <= CW'(OUTQ_DEPTH)))
        else $error("records pushed without room");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr == r_rd))
        else $error("empty queue with pointers apart");

endmodule

### hw/rtl/cytosine_context_scanner_top.sv
// Top level of the cytosine context scanner: window cells, counter, record queue.
//
// Usage:
//   Slave channel s_axis carries one sequence character per beat in tdata
//   (any case); tlast marks the final base of a sequence. Master channel
//   m_axis carries one record per beat: tdata = position, ctx_second,
//   ctx_third (lowest bits first); tuser = strand (0 plus, 1 minus);
//   tlast = last record caused by the same input beat.
//   Bases are judged two positions behind the input, so a record for the
//   base at n-2 leaves after the beat at n; the tlast beat flushes the two
//   pending bases plus itself, giving up to three records.
//   A record is registered in the record queue on the input beat that
//   decides it. Throughput: one input beat per cycle while s_axis_tready
//   is high; a tlast beat that yields three records stalls input while
//   the four-entry record queue drains.
//   A receiver stall fills the queue; s_axis_tready drops once fewer than
//   three entries are free, and no record is lost.
//   Reset (synchronous, active low) fills the window with N, clears the
//   position counter and empties the queue. The counter saturates.
module cytosine_context_scanner_top #(
    parameter int PositionBits = ccs_pkg::POSITION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] base_char
    input  logic        s_axis_tlast,   // seq_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] position, [39:32] ctx_second,
                                        // [47:40] ctx_third
    output logic [0:0]  m_axis_tuser,   // [0] strand
    output logic        m_axis_tlast    // last_of_run
);
    import ccs_pkg::*;

    localparam int PosExtBits = (PositionBits > 32) ? PositionBits : 32;
    localparam logic [PositionBits-1:0] CountMax = '1;

    logic                    accept;
    logic                    seq_end;
    logic [7:0]              x;
    logic [7:0]              win [4];
    logic                    shift;
    logic                    clear;
    logic [PositionBits-1:0] r_count;
    logic [PositionBits-1:0] n_count;
    logic [PositionBits-1:0] cnt_inc;
    logic [PosExtBits-1:0]   pos_ext0;
    logic [PosExtBits-1:0]   pos_ext1;
    logic [PosExtBits-1:0]   pos_ext2;
    logic [2:0]              vld;
    t_rec                    rec0;
    t_rec                    rec1;
    t_rec                    rec2;
    t_rec                    rec0_q;
    t_rec                    rec1_q;
    t_rec                    rec2_q;
    t_rec                    out_rec;
    logic                    room;

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign seq_end = s_axis_tlast;
    assign x       = to_upper(s_axis_tdata);
    assign shift   = accept && !seq_end;
    assign clear   = accept && seq_end;

    // Window chain: cell 0 is the newest base.
    for (genvar g = 0; g < 4; g++) begin : g_cell
        ccs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_clear (clear),
            .i_base  ((g == 0) ? x : win[(g == 0) ? 0 : g - 1]),
            .o_base  (win[g])
        );
    end

    // Saturating 1-based position of the incoming base.
    assign cnt_inc = (r_count != CountMax) ? r_count + 1'b1 : r_count;

    always_comb begin
        n_count = r_count;
        if (clear) begin
            n_count = '0;
        end else if (shift) begin
            n_count = cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Positions wrap within the counter width, then report the low 32 bits.
    assign pos_ext0 = PosExtBits'(PositionBits'(cnt_inc - PositionBits'(2)));
    assign pos_ext1 = PosExtBits'(PositionBits'(cnt_inc - PositionBits'(1)));
    assign pos_ext2 = PosExtBits'(cnt_inc);

    // Base at n-2 always; on sequence end also n-1 and n.
    assign rec0 = judge(win[1], pos_ext0[31:0], win[0], x, win[2], win[3]);
    assign rec1 = judge(win[0], pos_ext1[31:0], x, CHAR_N, win[1], win[2]);
    assign rec2 = judge(x, pos_ext2[31:0], CHAR_N, CHAR_N, win[0], win[1]);

    assign vld[0] = accept && is_cg(win[1]);
    assign vld[1] = clear && is_cg(win[0]);
    assign vld[2] = clear && is_cg(x);

    // Mark the final record of this beat.
    always_comb begin
        rec0_q = rec0;
        rec1_q = rec1;
        rec2_q = rec2;
        rec0_q.last_of_run = vld[0] && !vld[1] && !vld[2];
        rec1_q.last_of_run = vld[1] && !vld[2];
        rec2_q.last_of_run = vld[2];
    end

    ccs_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (vld),
        .i_rec0  (rec0_q),
        .i_rec1  (rec1_q),
        .i_rec2  (rec2_q),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_rec   (out_rec)
    );

    assign s_axis_tready = room;
    assign m_axis_tdata  = {out_rec.ctx_third, out_rec.ctx_second, out_rec.position};
    assign m_axis_tuser  = out_rec.strand;
    assign m_axis_tlast  = out_rec.last_of_run;

    a_end_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clear |=> (r_count == '0))
        else $error("counter not cleared at sequence end");

    a_end_clears_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clear |=> (win[0] == CHAR_N && win[1] == CHAR_N))
        else $error("window not cleared at sequence end");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (shift && r_count != CountMax) |=> (r_count == $past(r_count) + 1'b1))
        else $error("counter did not advance");

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the cytosine context scanner: directed table, random runs, scoreboard.
module testbench;
    import ccs_pkg::*;

    localparam int POS_BITS    = POSITION_BITS_DEF;
    localparam int TOTAL_BEATS = 410;
    localparam int IDLE_PCT    = 27;

    // ---------------------------------------------------------------
    // Clock, reset, DUT ports (all inputs known from time zero)
    // ---------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] base_char
    logic        s_axis_tlast  = 1'b0; // seq_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // [31:0] position, [39:32] ctx_second, [47:40] ctx_third
    logic [0:0]  m_axis_tuser;         // [0] strand
    logic        m_axis_tlast;         // last_of_run

    cytosine_context_scanner_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the handshakes hang.
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ---------------------------------------------------------------
    // Directed table. Rows flagged typed carry their expected records
    // inline (one-base sequences from an all-N window); the rest are
    // checked against the scan predictor.
    // ---------------------------------------------------------------
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        logic [1:0] n_typed;
        t_rec       rec;
    } t_stim_row;

    localparam int DIR_ROWS = 24;
    localparam t_stim_row DIRECTED [DIR_ROWS] = '{
        // single C: plus strand, context N N, position 1
        '{CHAR_C, 1'b1, 1'b1, 2'd1, '{32'd1, STRAND_PLUS,  CHAR_N, CHAR_N, 1'b1}},
        // single lower-case g: minus strand, nothing before it
        '{"g",    1'b1, 1'b1, 2'd1, '{32'd1, STRAND_MINUS, CHAR_N, CHAR_N, 1'b1}},
        // byte extremes as one-base sequences: no record
        '{8'h00,  1'b1, 1'b1, 2'd0, '0},
        '{8'hFF,  1'b1, 1'b1, 2'd0, '0},
        // mixed case run, chars around the a..z range
        '{"a",    1'b0, 1'b0, 2'd0, '0},
        '{"c",    1'b0, 1'b0, 2'd0, '0},
        '{"G",    1'b0, 1'b0, 2'd0, '0},
        '{"t",    1'b0, 1'b0, 2'd0, '0},
        '{"z",    1'b0, 1'b0, 2'd0, '0},
        '{8'h60,  1'b0, 1'b0, 2'd0, '0},
        '{8'h7B,  1'b0, 1'b0, 2'd0, '0},
        '{CHAR_C, 1'b0, 1'b0, 2'd0, '0},
        '{CHAR_G, 1'b0, 1'b0, 2'd0, '0},
        // end with C,G pending plus a final C: three records on one beat
        '{CHAR_C, 1'b1, 1'b0, 2'd0, '0},
        // two-base sequence
        '{CHAR_G, 1'b0, 1'b0, 2'd0, '0},
        '{CHAR_C, 1'b1, 1'b0, 2'd0, '0},
        // non-ACGT in minus-strand context complements to N
        '{"c",    1'b0, 1'b0, 2'd0, '0},
        '{"g",    1'b0, 1'b0, 2'd0, '0},
        '{CHAR_N, 1'b0, 1'b0, 2'd0, '0},
        '{8'h80,  1'b0, 1'b0, 2'd0, '0},
        '{CHAR_G, 1'b0, 1'b0, 2'd0, '0},
        '{8'h40,  1'b0, 1'b0, 2'd0, '0},
        '{CHAR_C, 1'b0, 1'b0, 2'd0, '0},
        '{CHAR_G, 1'b1, 1'b0, 2'd0, '0}
    };

    // ---------------------------------------------------------------
    // Scan predictor: four-base window (newest first) and saturating
    // position counter, two bases behind the input.
    // ---------------------------------------------------------------
    logic [7:0]          seq_window [4];
    logic [POS_BITS-1:0] seq_count;
    t_rec                beat_recs[$];      // records caused by the current beat
    t_rec                expected_recs[$];  // records still owed by the DUT

    int  errors   = 0;
    int  sent     = 0;
    bit  steady   = 1'b0;   // no idling on either side while set

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic logic [7:0] pair_of(input logic [7:0] c);
        case (c)
            CHAR_A:  return CHAR_T;
            CHAR_T:  return CHAR_A;
            CHAR_C:  return CHAR_G;
            CHAR_G:  return CHAR_C;
            default: return CHAR_N;
        endcase
    endfunction

    // Record for one decided base; nx* follow it, pv* precede it.
    function automatic void call_base(input logic [7:0] b, input logic [POS_BITS-1:0] pos,
                                      input logic [7:0] nx1, input logic [7:0] nx2,
                                      input logic [7:0] pv1, input logic [7:0] pv2);
        t_rec r;
        r.position    = 32'(pos);
        r.last_of_run = 1'b0;
        if (b == CHAR_C) begin
            r.strand     = STRAND_PLUS;
            r.ctx_second = nx1;
            r.ctx_third  = nx2;
            beat_recs.push_back(r);
        end else if (b == CHAR_G) begin
            r.strand     = STRAND_MINUS;
            r.ctx_second = pair_of(pv1);
            r.ctx_third  = pair_of(pv2);
            beat_recs.push_back(r);
        end
    endfunction

    function automatic void scan_beat(input logic [7:0] ch, input logic last);
        logic [7:0]          x;
        logic [POS_BITS-1:0] n;
        t_rec                r;
        x = fold_case(ch);
        n = seq_count;
        beat_recs.delete();
        if (n != '1) n++;
        call_base(seq_window[1], n - 2, seq_window[0], x, seq_window[2], seq_window[3]);
        if (last) begin
            call_base(seq_window[0], n - 1, x, CHAR_N, seq_window[1], seq_window[2]);
            call_base(x, n, CHAR_N, CHAR_N, seq_window[0], seq_window[1]);
            for (int i = 0; i < 4; i++) seq_window[i] = CHAR_N;
            seq_count = '0;
        end else begin
            seq_window[3] = seq_window[2];
            seq_window[2] = seq_window[1];
            seq_window[1] = seq_window[0];
            seq_window[0] = x;
            seq_count     = n;
        end
        if (beat_recs.size() > 0) begin
            r = beat_recs.pop_back();
            r.last_of_run = 1'b1;
            beat_recs.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------
    // Slave-side driver: optional random gap, then hold the beat until
    // tready is seen high at a rising edge. Returns on the accepting edge.
    // Each idle cycle is drawn at IDLE_PCT, so idling is IDLE_PCT of cycles.
    // ---------------------------------------------------------------
    task automatic send_beat(input logic [7:0] ch, input logic last);
        int gap;
        gap = 0;
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PCT) gap++;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
        steady = (sent >= 120 && sent < 220);
    endtask

    // Drive one random-part beat and queue whatever the predictor expects.
    task automatic feed_beat(input logic [7:0] ch, input logic last);
        send_beat(ch, last);
        scan_beat(ch, last);
        foreach (beat_recs[j]) expected_recs.push_back(beat_recs[j]);
    endtask

    // ---------------------------------------------------------------
    // Master-side monitor and scoreboard. Samples at the rising edge,
    // then picks the next tready (random stalls outside the steady run).
    // ---------------------------------------------------------------
    initial begin
        t_rec want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (expected_recs.size() == 0) begin
                    $error("record with nothing expected: position %0d", m_axis_tdata[31:0]);
                    errors++;
                end else begin
                    want = expected_recs.pop_front();
                    if (m_axis_tdata[31:0] !== want.position) begin
                        $error("position: expected %0d, got %0d",
                               want.position, m_axis_tdata[31:0]);
                        errors++;
                    end
                    if (m_axis_tuser[0] !== want.strand) begin
                        $error("strand: expected %0d, got %0d", want.strand, m_axis_tuser[0]);
                        errors++;
                    end
                    if (m_axis_tdata[39:32] !== want.ctx_second) begin
                        $error("ctx_second: expected %h, got %h",
                               want.ctx_second, m_axis_tdata[39:32]);
                        errors++;
                    end
                    if (m_axis_tdata[47:40] !== want.ctx_third) begin
                        $error("ctx_third: expected %h, got %h",
                               want.ctx_third, m_axis_tdata[47:40]);
                        errors++;
                    end
                    if (m_axis_tlast !== want.last_of_run) begin
                        $error("last_of_run: expected %0d, got %0d",
                               want.last_of_run, m_axis_tlast);
                        errors++;
                    end
                end
            end
            m_axis_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    string base_pool = "ACGTacgtACGTNn";

    initial begin
        int         len;
        int         pick;
        logic [7:0] ch;
        bit         paused;

        for (int i = 0; i < 4; i++) seq_window[i] = CHAR_N;
        seq_count = '0;
        paused    = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            send_beat(DIRECTED[i].ch, DIRECTED[i].last);
            scan_beat(DIRECTED[i].ch, DIRECTED[i].last);
            if (DIRECTED[i].typed) begin
                for (int j = 0; j < DIRECTED[i].n_typed; j++)
                    expected_recs.push_back(DIRECTED[i].rec);
            end else begin
                foreach (beat_recs[j]) expected_recs.push_back(beat_recs[j]);
            end
        end

        // Hold off until the queue is fully drained before going random.
        s_axis_tvalid <= 1'b0;
        wait (expected_recs.size() == 0);
        @(posedge i_clk);

        // Random sequences: mostly short, some one to three bases, mostly
        // ACGT in either case with occasional N and arbitrary bytes.
        while (sent < TOTAL_BEATS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
            for (int k = 0; k < len; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 85) ch = base_pool[$urandom_range(0, base_pool.len() - 1)];
                else           ch = 8'($urandom_range(0, 255));
                feed_beat(ch, k == len - 1);
            end
            // One mid-run drain with the sender paused.
            if (!paused && sent >= 300) begin
                paused = 1'b1;
                s_axis_tvalid <= 1'b0;
                wait (expected_recs.size() == 0);
                @(posedge i_clk);
            end
        end

        s_axis_tvalid <= 1'b0;
        wait (expected_recs.size() == 0);
        repeat (8) @(posedge i_clk);

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
